### hw/rtl/bucketed_hash_table_aged_replace_top_macros.svh
// Assertion macros for the bucketed hash table block.
// Used by the top level; compiled out when SYNTH is defined.
`ifndef BUCKETED_HASH_TABLE_AGED_REPLACE_TOP_MACROS_SVH
`define BUCKETED_HASH_TABLE_AGED_REPLACE_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on i_clk, off during reset
`define BHTAR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BHTAR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BHTAR_ASSERT_IMP(lbl, ante, cons, msg)
`define BHTAR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/bhtar_pkg.sv
// Shared types and constants for the bucketed hash table block.
// No dependencies; used by bhtar_bucket and the top level.
package bhtar_pkg;

    localparam int KEY_W          = 64;
    localparam int TAG_W          = 16;
    localparam int TAG_SHIFT      = 48;
    localparam int AGE_W          = 6;
    localparam int SHALLOW_MARGIN = 2;

    localparam logic [1:0]  BOUND_EXACT = 2'd3;
    localparam logic [15:0] NO_MOVE     = 16'd0;

    // request codes
    typedef enum logic [1:0] {
        OP_PROBE      = 2'd0,
        OP_STORE      = 2'd1,
        OP_NEW_SEARCH = 2'd2
    } t_op;

    // one way, tag/depth/age/bound half (32 bits)
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic signed [7:0] depth;
        logic [AGE_W-1:0]  age;
        logic [1:0]        bound;
    } t_way_tda;

    // one way, value/eval/move half (48 bits)
    typedef struct packed {
        logic signed [15:0] value;
        logic signed [15:0] eval;
        logic [15:0]        move;
    } t_way_vem;

    // registered request, bucket index held separately
    typedef struct packed {
        logic [1:0]         op;
        logic [TAG_W-1:0]   tag;
        logic signed [7:0]  depth;
        logic [1:0]         bound;
        logic signed [15:0] value;
        logic signed [15:0] eval;
        logic [15:0]        move;
    } t_req;

    // bucket update outcome
    typedef struct packed {
        logic               we;
        logic               hit;
        logic               written;
        logic signed [7:0]  found_depth;
        logic [1:0]         found_bound;
        logic signed [15:0] found_value;
        logic signed [15:0] found_eval;
        logic [15:0]        found_move;
    } t_res;

endpackage

### hw/rtl/bhtar_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module bhtar_ram #(
    parameter int WIDTH     = 96,
    parameter int ADDR_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_BITS];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bhtar_bucket.sv
// Bucket update logic: tag match, replacement choice and row rewrite.
// Depends on bhtar_pkg.
module bhtar_bucket #(
    parameter int WAYS = 3
) (
    input  bhtar_pkg::t_req                  i_req,
    input  logic [bhtar_pkg::AGE_W-1:0]      i_age,
    input  bhtar_pkg::t_way_tda [WAYS-1:0]   i_tda_row,
    input  bhtar_pkg::t_way_vem [WAYS-1:0]   i_vem_row,
    output bhtar_pkg::t_way_tda [WAYS-1:0]   o_tda_row,
    output bhtar_pkg::t_way_vem [WAYS-1:0]   o_vem_row,
    output bhtar_pkg::t_res                  o_res
);

    logic [WAYS-1:0]             w_match;
    logic [bhtar_pkg::AGE_W-1:0] w_dist  [WAYS];
    logic signed [8:0]           w_score [WAYS];
    logic                        w_found;
    logic [WAYS-1:0]             w_match_oh;
    logic [WAYS-1:0]             w_vic_oh;
    logic signed [8:0]           w_vic_score;
    logic [WAYS-1:0]             w_sel_oh;
    bhtar_pkg::t_way_tda         w_old_tda;
    bhtar_pkg::t_way_vem         w_old_vem;
    logic signed [9:0]           w_new_depth;
    logic signed [9:0]           w_limit;
    logic                        w_shallow;
    logic                        w_keep_move;

    // per-way tag match and replacement score (depth minus age distance)
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_match[i] = (i_tda_row[i].tag == i_req.tag);
            w_dist[i]  = i_age - i_tda_row[i].age;
            w_score[i] = {i_tda_row[i].depth[7], i_tda_row[i].depth} - {3'b000, w_dist[i]};
        end
    end

    // first matching way; otherwise lowest score, later way wins ties
    always_comb begin
        w_found     = 1'b0;
        w_match_oh  = '0;
        w_vic_oh    = '0;
        w_vic_score = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!w_found) begin
                if (w_match[i]) begin
                    w_found       = 1'b1;
                    w_match_oh[i] = 1'b1;
                end else if (i == 0 || w_vic_score >= w_score[i]) begin
                    w_vic_oh      = '0;
                    w_vic_oh[i]   = 1'b1;
                    w_vic_score   = w_score[i];
                end
            end
        end
    end

    assign w_sel_oh = w_found ? w_match_oh : w_vic_oh;

    // and-or mux of the selected way
    always_comb begin
        w_old_tda = '0;
        w_old_vem = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (w_sel_oh[i]) begin
                w_old_tda = w_old_tda | i_tda_row[i];
                w_old_vem = w_old_vem | i_vem_row[i];
            end
        end
    end

    // shallow store skip and move retention
    assign w_new_depth = {{2{i_req.depth[7]}}, i_req.depth};
    assign w_limit     = {{2{w_old_tda.depth[7]}}, w_old_tda.depth}
                         - 10'(bhtar_pkg::SHALLOW_MARGIN);
    assign w_shallow   = w_found && (i_req.bound != bhtar_pkg::BOUND_EXACT)
                         && (w_new_depth < w_limit);
    assign w_keep_move = w_found && (i_req.move == bhtar_pkg::NO_MOVE);

    // row rewrite and result
    always_comb begin
        o_tda_row = i_tda_row;
        o_vem_row = i_vem_row;
        o_res     = '0;
        unique case (i_req.op)
            bhtar_pkg::OP_PROBE: begin
                if (w_found) begin
                    o_res.we          = 1'b1;
                    o_res.hit         = 1'b1;
                    o_res.found_depth = w_old_tda.depth;
                    o_res.found_bound = w_old_tda.bound;
                    o_res.found_value = w_old_vem.value;
                    o_res.found_eval  = w_old_vem.eval;
                    o_res.found_move  = w_old_vem.move;
                    for (int i = 0; i < WAYS; i++) begin
                        if (w_sel_oh[i]) begin
                            o_tda_row[i].age = i_age;
                        end
                    end
                end
            end
            bhtar_pkg::OP_STORE: begin
                if (!w_shallow) begin
                    o_res.we      = 1'b1;
                    o_res.written = 1'b1;
                    for (int i = 0; i < WAYS; i++) begin
                        if (w_sel_oh[i]) begin
                            o_tda_row[i].tag   = i_req.tag;
                            o_tda_row[i].depth = i_req.depth;
                            o_tda_row[i].age   = i_age;
                            o_tda_row[i].bound = i_req.bound;
                            o_vem_row[i].value = i_req.value;
                            o_vem_row[i].eval  = i_req.eval;
                            o_vem_row[i].move  = w_keep_move ? w_old_vem.move
                                                             : i_req.move;
                        end
                    end
                end
            end
            default: begin
                // new search and unused code leave the bucket alone
            end
        endcase
    end

endmodule

### hw/rtl/bucketed_hash_table_aged_replace_top.sv
// Top level of the bucketed hash table: control, age counter, bucket memories.
// Depends on bhtar_pkg, bhtar_ram, bhtar_bucket and the assertion macro header.
//
// After reset the block sweeps both bucket memories to zero, one bucket per
// cycle, with busy high. After that each request (probe, store or new search)
// is handled in order: the bucket row is read on the accepting edge, and on
// the next edge the updated row is written back and the result registered.
// o_done is high for exactly one cycle after that; the receiver cannot stall,
// so it must take the result then. busy is low again in that cycle, so a new
// request is accepted only once the last one is through, as the bucket memory
// has a registered read.
`include "bucketed_hash_table_aged_replace_top_macros.svh"

module bucketed_hash_table_aged_replace_top #(
    parameter int INDEX_BITS = 12,
    parameter int WAYS       = 3,
    parameter int MOVE_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [63:0]        i_key,
    input  logic signed [7:0]  i_depth,
    input  logic [1:0]         i_bound,
    input  logic signed [15:0] i_value,
    input  logic signed [15:0] i_eval,
    input  logic [15:0]        i_move,
    output logic               o_done,
    output logic               o_hit,
    output logic               o_written,
    output logic signed [7:0]  o_found_depth,
    output logic [1:0]         o_found_bound,
    output logic signed [15:0] o_found_value,
    output logic signed [15:0] o_found_eval,
    output logic [15:0]        o_found_move
);

    localparam int TdaW = WAYS * $bits(bhtar_pkg::t_way_tda);
    localparam int VemW = WAYS * $bits(bhtar_pkg::t_way_vem);
    localparam logic [15:0] MoveMask =
        (MOVE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << MOVE_BITS) - 32'd1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_PROC  = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [INDEX_BITS-1:0]         r_clr_idx, n_clr_idx;
    logic [bhtar_pkg::AGE_W-1:0]   r_search_age, n_search_age;
    logic                          r_done, n_done;
    bhtar_pkg::t_req               r_req;
    logic [INDEX_BITS-1:0]         r_idx;
    bhtar_pkg::t_res               r_res;

    logic                          w_accept;
    logic                          w_we;
    logic [INDEX_BITS-1:0]         w_waddr;
    logic [TdaW-1:0]               w_tda_wdata;
    logic [VemW-1:0]               w_vem_wdata;
    logic [TdaW-1:0]               w_tda_rdata;
    logic [VemW-1:0]               w_vem_rdata;
    bhtar_pkg::t_way_tda [WAYS-1:0] w_tda_row_in, w_tda_row_out;
    bhtar_pkg::t_way_vem [WAYS-1:0] w_vem_row_in, w_vem_row_out;
    bhtar_pkg::t_res               w_res;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // control state machine and search age
    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_search_age = r_search_age;
        n_done       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_PROC;
                end
            end
            ST_PROC: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (r_req.op == bhtar_pkg::OP_NEW_SEARCH) begin
                    n_search_age = r_search_age + 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_search_age <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_search_age <= n_search_age;
            r_done       <= n_done;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.op    <= i_op;
            r_req.tag   <= i_key[bhtar_pkg::TAG_SHIFT +: bhtar_pkg::TAG_W];
            r_req.depth <= i_depth;
            r_req.bound <= i_bound;
            r_req.value <= i_value;
            r_req.eval  <= i_eval;
            r_req.move  <= i_move & MoveMask;
            r_idx       <= i_key[INDEX_BITS-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PROC) begin
            r_res <= w_res;
        end
    end

    // memory write mux: clearing sweep or bucket write-back
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we        = 1'b1;
            w_waddr     = r_clr_idx;
            w_tda_wdata = '0;
            w_vem_wdata = '0;
        end else begin
            w_we        = (r_state == ST_PROC) && w_res.we;
            w_waddr     = r_idx;
            w_tda_wdata = w_tda_row_out;
            w_vem_wdata = w_vem_row_out;
        end
    end

    bhtar_ram #(
        .WIDTH     (TdaW),
        .ADDR_BITS (INDEX_BITS)
    ) u_tda_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_tda_wdata),
        .i_re    (w_accept),
        .i_raddr (i_key[INDEX_BITS-1:0]),
        .o_rdata (w_tda_rdata)
    );

    bhtar_ram #(
        .WIDTH     (VemW),
        .ADDR_BITS (INDEX_BITS)
    ) u_vem_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_vem_wdata),
        .i_re    (w_accept),
        .i_raddr (i_key[INDEX_BITS-1:0]),
        .o_rdata (w_vem_rdata)
    );

    assign w_tda_row_in = w_tda_rdata;
    assign w_vem_row_in = w_vem_rdata;

    bhtar_bucket #(
        .WAYS (WAYS)
    ) u_bucket (
        .i_req     (r_req),
        .i_age     (r_search_age),
        .i_tda_row (w_tda_row_in),
        .i_vem_row (w_vem_row_in),
        .o_tda_row (w_tda_row_out),
        .o_vem_row (w_vem_row_out),
        .o_res     (w_res)
    );

    // outputs
    assign o_done        = r_done;
    assign o_hit         = r_done && r_res.hit;
    assign o_written     = r_done && r_res.written;
    assign o_found_depth = r_res.found_depth;
    assign o_found_bound = r_res.found_bound;
    assign o_found_value = r_res.found_value;
    assign o_found_eval  = r_res.found_eval;
    assign o_found_move  = r_res.found_move;

    // checks
    `BHTAR_ASSERT_NXT(a_accept_to_proc, w_accept, r_state == ST_PROC, "accept did not start work")
    `BHTAR_ASSERT_NXT(a_proc_to_done, r_state == ST_PROC, r_done, "missing result strobe")
    `BHTAR_ASSERT_IMP(a_done_in_idle, r_done, r_state == ST_IDLE, "result strobe while busy")
    `BHTAR_ASSERT_IMP(a_hit_xor_written, o_written, !o_hit, "store reported a hit")
    `BHTAR_ASSERT_IMP(a_no_write_idle, r_state == ST_IDLE, !w_we, "memory write while idle")

endmodule

### bench/tb.sv
// Testbench for bucketed_hash_table_aged_replace_top: directed and random requests,
// every result checked against a cycle-free model of the bucket table held here.
// Depends on bhtar_pkg and the RTL of the top level.
`timescale 1ns / 100ps

module tb;

    localparam int INDEX_BITS = 12;
    localparam int WAYS       = 3;
    localparam int MOVE_BITS  = 16;
    localparam int SLOTS      = (1 << INDEX_BITS) * WAYS;

    // fourth request code, not in t_op: the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one expected or observed result
    typedef struct packed {
        logic               hit;
        logic               written;
        logic signed [7:0]  found_depth;
        logic [1:0]         found_bound;
        logic signed [15:0] found_value;
        logic signed [15:0] found_eval;
        logic [15:0]        found_move;
    } t_outcome;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_op;
    logic [63:0]        i_key;
    logic signed [7:0]  i_depth;
    logic [1:0]         i_bound;
    logic signed [15:0] i_value;
    logic signed [15:0] i_eval;
    logic [15:0]        i_move;
    logic               o_done;
    logic               o_hit;
    logic               o_written;
    logic signed [7:0]  o_found_depth;
    logic [1:0]         o_found_bound;
    logic signed [15:0] o_found_value;
    logic signed [15:0] o_found_eval;
    logic [15:0]        o_found_move;

    // mirror of the table and the search age
    bhtar_pkg::t_way_tda          tda_mirror [SLOTS];
    bhtar_pkg::t_way_vem          vem_mirror [SLOTS];
    logic [bhtar_pkg::AGE_W-1:0]  age_mirror;

    t_outcome pending_results[$];
    int       mismatch_count = 0;
    bit       no_idle = 1'b0;

    // a few buckets and tags so that random requests collide often
    logic [11:0] hot_buckets [4] = '{12'h000, 12'hFFF, 12'h5A5, 12'h123};
    logic [15:0] hot_tags    [6] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h1357,
                                     16'h0001, 16'h7FFE};

    bucketed_hash_table_aged_replace_top #(
        .INDEX_BITS (INDEX_BITS),
        .WAYS       (WAYS),
        .MOVE_BITS  (MOVE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_depth       (i_depth),
        .i_bound       (i_bound),
        .i_value       (i_value),
        .i_eval        (i_eval),
        .i_move        (i_move),
        .o_done        (o_done),
        .o_hit         (o_hit),
        .o_written     (o_written),
        .o_found_depth (o_found_depth),
        .o_found_bound (o_found_bound),
        .o_found_value (o_found_value),
        .o_found_eval  (o_found_eval),
        .o_found_move  (o_found_move)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // replacement score: depth minus age distance (mod 64)
    function automatic int way_score(bhtar_pkg::t_way_tda w);
        logic [bhtar_pkg::AGE_W-1:0] age_gap;
        age_gap = age_mirror - w.age;
        return int'(w.depth) - int'(age_gap);
    endfunction

    // apply one request to the mirror and return the result it must produce
    function automatic t_outcome hash_table_step(logic [1:0] op, logic [63:0] key,
                                                 logic signed [7:0] depth, logic [1:0] bound,
                                                 logic signed [15:0] value,
                                                 logic signed [15:0] eval,
                                                 logic [15:0] move);
        t_outcome res;
        int       base;
        int       victim;
        bit       matched;
        logic [bhtar_pkg::TAG_W-1:0] tag;
        bhtar_pkg::t_way_tda w;
        res     = '0;
        base    = int'(key[INDEX_BITS-1:0]) * WAYS;
        tag     = key[bhtar_pkg::TAG_SHIFT +: bhtar_pkg::TAG_W];
        victim  = base;
        matched = 1'b0;
        case (op)
            bhtar_pkg::OP_PROBE: begin
                for (int i = 0; i < WAYS; i++) begin
                    if (tda_mirror[base + i].tag == tag) begin
                        tda_mirror[base + i].age = age_mirror;
                        w = tda_mirror[base + i];
                        res.hit         = 1'b1;
                        res.found_depth = w.depth;
                        res.found_bound = w.bound;
                        res.found_value = vem_mirror[base + i].value;
                        res.found_eval  = vem_mirror[base + i].eval;
                        res.found_move  = vem_mirror[base + i].move;
                        break;
                    end
                end
            end
            bhtar_pkg::OP_STORE: begin
                for (int i = 0; i < WAYS; i++) begin
                    if (tda_mirror[base + i].tag == tag) begin
                        victim  = base + i;
                        matched = 1'b1;
                        break;
                    end
                    // ties go to the later way
                    if (way_score(tda_mirror[victim]) >= way_score(tda_mirror[base + i]))
                        victim = base + i;
                end
                w = tda_mirror[victim];
                // shallow store on a matching way is dropped
                if (!(matched && bound != bhtar_pkg::BOUND_EXACT &&
                      int'(depth) < int'(w.depth) - bhtar_pkg::SHALLOW_MARGIN)) begin
                    vem_mirror[victim].value = value;
                    vem_mirror[victim].eval  = eval;
                    if (!(matched && move == bhtar_pkg::NO_MOVE))
                        vem_mirror[victim].move = move;
                    w.tag   = tag;
                    w.depth = depth;
                    w.age   = age_mirror;
                    w.bound = bound;
                    tda_mirror[victim] = w;
                    res.written = 1'b1;
                end
            end
            bhtar_pkg::OP_NEW_SEARCH: age_mirror = age_mirror + 1'b1;
            default: ;
        endcase
        return res;
    endfunction

    function automatic string outcome_text(t_outcome r);
        return $sformatf("hit=%0b written=%0b depth=%0d bound=%0d value=%0d eval=%0d move=%h",
                         r.hit, r.written, r.found_depth, r.found_bound,
                         r.found_value, r.found_eval, r.found_move);
    endfunction

    // send one request, record its expected result, then idle a random while
    task automatic send_req(input logic [1:0] op, input logic [63:0] key,
                            input logic signed [7:0] depth, input logic [1:0] bound,
                            input logic signed [15:0] value, input logic signed [15:0] eval,
                            input logic [15:0] move);
        int idle;
        @(negedge i_clk);
        start   <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        i_depth <= depth;
        i_bound <= bound;
        i_value <= value;
        i_eval  <= eval;
        i_move  <= move;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(hash_table_step(op, key, depth, bound, value, eval, move));
        idle = no_idle ? 0 : $urandom_range(5, 0);
        if (idle > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
    endtask

    // hold off new requests until every result is back
    task automatic wait_all_results;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // cleared ways carry tag 0; unknown op does nothing
    task automatic test_empty_ways;
        send_req(bhtar_pkg::OP_PROBE, 64'h0000_1234_5678_9000, 8'sd0, 2'd0, 16'sd0, 16'sd0,
                 16'h0);
        send_req(bhtar_pkg::OP_PROBE, 64'h8001_0000_0000_0ABC, 8'sd0, 2'd0, 16'sd0, 16'sd0,
                 16'h0);
        send_req(OP_UNUSED, '1, 8'sd127, 2'd3, 16'sh7FFF, -16'sd1, 16'hFFFF);
    endtask

    // field extremes through store and probe
    task automatic test_field_extremes;
        send_req(bhtar_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 8'sd127, bhtar_pkg::BOUND_EXACT,
                 -16'sd32768, 16'sd32767, 16'hFFFF);
        send_req(bhtar_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'sd0, 2'd0, 16'sd0, 16'sd0,
                 16'h0);
        send_req(bhtar_pkg::OP_STORE, 64'h7FFE_0000_0000_0FFF, -8'sd128, 2'd0,
                 16'sd32767, -16'sd32768, 16'h0001);
        send_req(bhtar_pkg::OP_PROBE, 64'h7FFE_0000_0000_0FFF, 8'sd0, 2'd0, 16'sd0, 16'sd0,
                 16'h0);
        send_req(bhtar_pkg::OP_PROBE, 64'hFFFF_0000_0000_0FFF, 8'sd0, 2'd0, 16'sd0, 16'sd0,
                 16'h0);
    endtask

    // shallow stores are dropped, a missing move keeps the old one
    task automatic test_shallow_and_move;
        logic [63:0] key;
        key = 64'h1357_0000_0000_0005;
        send_req(bhtar_pkg::OP_STORE, key, 8'sd10, 2'd1, 16'sd100, 16'sd50, 16'hABCD);
        send_req(bhtar_pkg::OP_STORE, key, 8'sd7, 2'd1, 16'sd101, 16'sd51, 16'h1111);
        send_req(bhtar_pkg::OP_STORE, key, 8'sd7, bhtar_pkg::BOUND_EXACT, 16'sd102, 16'sd52,
                 bhtar_pkg::NO_MOVE);
        send_req(bhtar_pkg::OP_STORE, key, 8'sd5, 2'd2, 16'sd103, 16'sd53, bhtar_pkg::NO_MOVE);
        send_req(bhtar_pkg::OP_STORE, key, 8'sd2, 2'd2, 16'sd104, 16'sd54, 16'h2222);
        send_req(bhtar_pkg::OP_PROBE, key, 8'sd0, 2'd0, 16'sd0, 16'sd0, 16'h0);
    endtask

    // fill a bucket, age it, then force an eviction
    task automatic test_replacement;
        send_req(bhtar_pkg::OP_STORE, 64'h0001_0000_0000_0009, 8'sd20, 2'd1, 16'sd1, 16'sd1,
                 16'h0101);
        send_req(bhtar_pkg::OP_STORE, 64'h0002_0000_0000_0009, 8'sd5, 2'd2, 16'sd2, 16'sd2,
                 16'h0202);
        send_req(bhtar_pkg::OP_STORE, 64'h0003_0000_0000_0009, 8'sd12, 2'd3, 16'sd3, 16'sd3,
                 16'h0303);
        send_req(bhtar_pkg::OP_NEW_SEARCH, 64'h0, 8'sd0, 2'd0, 16'sd0, 16'sd0, 16'h0);
        send_req(bhtar_pkg::OP_NEW_SEARCH, 64'h0, 8'sd0, 2'd0, 16'sd0, 16'sd0, 16'h0);
        send_req(bhtar_pkg::OP_STORE, 64'h0004_0000_0000_0009, 8'sd0, 2'd0, 16'sd4, 16'sd4,
                 16'h0404);
        send_req(bhtar_pkg::OP_PROBE, 64'h0002_0000_0000_0009, 8'sd0, 2'd0, 16'sd0, 16'sd0,
                 16'h0);
        send_req(bhtar_pkg::OP_PROBE, 64'h0004_0000_0000_0009, 8'sd0, 2'd0, 16'sd0, 16'sd0,
                 16'h0);
    endtask

    // random requests, mostly on a few hot buckets and tags
    task automatic test_random(input int count);
        logic [1:0]  op;
        logic [63:0] key;
        logic [7:0]  depth;
        logic [15:0] move;
        int          pick;
        int          d;
        for (int n = 0; n < count; n++) begin
            // alternate stretches with and without idle cycles
            if (n % 40 == 0)
                no_idle = ($urandom_range(3, 0) == 0);
            pick = $urandom_range(99, 0);
            if (pick < 40)
                op = bhtar_pkg::OP_PROBE;
            else if (pick < 80)
                op = bhtar_pkg::OP_STORE;
            else if (pick < 95)
                op = bhtar_pkg::OP_NEW_SEARCH;
            else
                op = OP_UNUSED;
            key = {$urandom, $urandom};
            if ($urandom_range(99, 0) < 85) begin
                key[11:0]  = hot_buckets[$urandom_range(3, 0)];
                key[63:48] = hot_tags[$urandom_range(5, 0)];
            end
            if ($urandom_range(99, 0) < 75) begin
                d = int'($urandom_range(30, 0)) - 10;
                depth = d[7:0];
            end else begin
                depth = 8'($urandom);
            end
            move = ($urandom_range(3, 0) == 0) ? bhtar_pkg::NO_MOVE : 16'($urandom);
            send_req(op, key, depth, 2'($urandom), 16'($urandom), 16'($urandom), move);
        end
        no_idle = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_done) begin
            got = '{o_hit, o_written, o_found_depth, o_found_bound,
                    o_found_value, o_found_eval, o_found_move};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %s", outcome_text(got));
            end else begin
                want = pending_results.pop_front();
                if (want.hit !== got.hit || want.written !== got.written ||
                    want.found_depth !== got.found_depth ||
                    want.found_bound !== got.found_bound ||
                    want.found_value !== got.found_value ||
                    want.found_eval !== got.found_eval ||
                    want.found_move !== got.found_move) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch at %0t\n  expected %s\n  actual   %s",
                                 $realtime, outcome_text(want), outcome_text(got));
                end
            end
        end
    end

    // main sequence
    initial begin
        start      = 1'b0;
        i_rst_n    = 1'b0;
        i_op       = bhtar_pkg::OP_PROBE;
        i_key      = '0;
        i_depth    = '0;
        i_bound    = '0;
        i_value    = '0;
        i_eval     = '0;
        i_move     = '0;
        age_mirror = '0;
        foreach (tda_mirror[s]) begin
            tda_mirror[s] = '0;
            vem_mirror[s] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_ways();
        test_field_extremes();
        test_shallow_and_move();
        test_replacement();
        test_random(250);
        wait_all_results();
        test_random(250);
        wait_all_results();
        repeat (5) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("bucketed_hash_table_aged_replace_top test passed");
        else
            $display("bucketed_hash_table_aged_replace_top test failed");
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("bucketed_hash_table_aged_replace_top test failed");
        $finish;
    end

endmodule
